// ===== rtl/apom_pkg.sv =====
`timescale 1ns / 1ps

package apom_pkg;

    localparam int PEAK_DECIMATION     = 64;
    localparam int OVERVIEW_DECIMATION = 2048;
    localparam int POSITION_BITS       = 24;

    localparam int SAMPLE_W        = 16;
    localparam int LEVEL_W         = 16;
    localparam int OV_ENV_W        = 32;
    localparam int METER_W         = 8;
    localparam int PEAK_SLOT_W     = 18;
    localparam int OV_SLOT_W       = 13;

    localparam int PEAK_ATTACK_SH  = 3;
    localparam int PEAK_RELEASE_SH = 9;
    localparam int OV_ATTACK_SH    = 8;
    localparam int OV_RELEASE_SH   = 17;

    localparam int PEAK_PH_W = (PEAK_DECIMATION > 1) ? $clog2(PEAK_DECIMATION) : 1;
    localparam int OV_PH_W   = (OVERVIEW_DECIMATION > 1) ? $clog2(OVERVIEW_DECIMATION) : 1;

    typedef struct packed {
        logic [PEAK_SLOT_W-1:0] peak_slot;
        logic                   peak_done;
        logic [OV_SLOT_W-1:0]   ov_slot;
        logic                   ov_done;
    } t_slot_info;

endpackage

// ===== rtl/apom_slot.sv =====
`timescale 1ns / 1ps

module apom_slot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_clear,
    output apom_pkg::t_slot_info o_info
);
    import apom_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [PEAK_PH_W-1:0] PEAK_PH_LAST = PEAK_PH_W'(PEAK_DECIMATION - 1);
    localparam logic [OV_PH_W-1:0]   OV_PH_LAST   = OV_PH_W'(OVERVIEW_DECIMATION - 1);

    logic [POSITION_BITS-1:0] r_pos, n_pos, cur_pos;
    logic [PEAK_PH_W-1:0]     r_peak_ph, n_peak_ph, cur_peak_ph;
    logic [OV_PH_W-1:0]       r_ov_ph, n_ov_ph, cur_ov_ph;
    logic [PEAK_SLOT_W-1:0]   r_peak_slot, n_peak_slot, cur_peak_slot;
    logic [OV_SLOT_W-1:0]     r_ov_slot, n_ov_slot, cur_ov_slot;
    logic                     at_max;
    logic                     peak_wrap;
    logic                     ov_wrap;

    always_comb begin
        cur_pos       = i_clear ? '0 : r_pos;
        cur_peak_ph   = i_clear ? '0 : r_peak_ph;
        cur_ov_ph     = i_clear ? '0 : r_ov_ph;
        cur_peak_slot = i_clear ? '0 : r_peak_slot;
        cur_ov_slot   = i_clear ? '0 : r_ov_slot;

        at_max    = (cur_pos == POS_MAX);
        peak_wrap = (cur_peak_ph == PEAK_PH_LAST);
        ov_wrap   = (cur_ov_ph == OV_PH_LAST);

        o_info.peak_slot = cur_peak_slot;
        o_info.peak_done = at_max || peak_wrap;
        o_info.ov_slot   = cur_ov_slot;
        o_info.ov_done   = at_max || ov_wrap;

        if (at_max) begin
            n_pos       = '0;
            n_peak_ph   = '0;
            n_ov_ph     = '0;
            n_peak_slot = '0;
            n_ov_slot   = '0;
        end else begin
            n_pos       = cur_pos + 1'b1;
            n_peak_ph   = peak_wrap ? '0 : cur_peak_ph + 1'b1;
            n_ov_ph     = ov_wrap ? '0 : cur_ov_ph + 1'b1;
            n_peak_slot = cur_peak_slot + PEAK_SLOT_W'(peak_wrap);
            n_ov_slot   = cur_ov_slot + OV_SLOT_W'(ov_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_peak_ph   <= '0;
            r_ov_ph     <= '0;
            r_peak_slot <= '0;
            r_ov_slot   <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_peak_ph   <= n_peak_ph;
            r_ov_ph     <= n_ov_ph;
            r_peak_slot <= n_peak_slot;
            r_ov_slot   <= n_ov_slot;
        end
    end

`ifndef ASSERT_OFF
    a_peak_ph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_ph <= PEAK_PH_LAST)
        else $error("peak phase out of range");

    a_ov_ph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov_ph <= OV_PH_LAST)
        else $error("overview phase out of range");

    a_clear_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_clear |=> r_pos == POSITION_BITS'(1))
        else $error("position did not restart after clear");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos))
        else $error("position moved without a step");
`endif

endmodule

// ===== rtl/audio_peak_and_overview_meter_top.sv =====
`timescale 1ns / 1ps
// channel  | handshake          | payload
// in       | i_valid / o_ready  | i_left_sample, i_right_sample, i_track_start
// out      | o_valid / i_ready  | o_peak_level, o_overview_level, o_peak_slot,
//          |                    | o_peak_slot_done, o_overview_slot, o_overview_slot_done
//
// one item per cycle sustained while the output is not stalled
// input register then result register, envelope and counter update in between
// reset clears envelopes, sample counter and both valid flags
// a stalled result holds, and one more item waits in the input register

module audio_peak_and_overview_meter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [apom_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [apom_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                            i_track_start,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [apom_pkg::METER_W-1:0]     o_peak_level,
    output logic [apom_pkg::METER_W-1:0]     o_overview_level,
    output logic [apom_pkg::PEAK_SLOT_W-1:0] o_peak_slot,
    output logic                            o_peak_slot_done,
    output logic [apom_pkg::OV_SLOT_W-1:0]   o_overview_slot,
    output logic                            o_overview_slot_done
);
    import apom_pkg::*;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_left;
    logic [SAMPLE_W-1:0] r_in_right;
    logic                r_in_start;

    logic                r_out_valid;
    logic [METER_W-1:0]  r_peak_level;
    logic [METER_W-1:0]  r_ov_level;
    t_slot_info          r_info;

    logic [LEVEL_W-1:0]  r_peak_env, n_peak_env, cur_peak_env;
    logic [OV_ENV_W-1:0] r_ov_env, n_ov_env, cur_ov_env;

    logic                advance;
    logic                in_xfer;
    logic [SAMPLE_W:0]   mag_l, mag_r;
    logic [SAMPLE_W+1:0] level_sum;
    logic [LEVEL_W-1:0]  level;
    logic [OV_ENV_W-1:0] level_w;
    logic [LEVEL_W-1:0]  peak_diff;
    logic [OV_ENV_W-1:0] ov_diff;
    t_slot_info          slot_info;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    apom_slot u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_clear (r_in_start),
        .o_info  (slot_info)
    );

    always_comb begin
        mag_l = r_in_left[SAMPLE_W-1]
              ? (SAMPLE_W+1)'(0) - {1'b1, r_in_left} : {1'b0, r_in_left};
        mag_r = r_in_right[SAMPLE_W-1]
              ? (SAMPLE_W+1)'(0) - {1'b1, r_in_right} : {1'b0, r_in_right};
        level_sum = {1'b0, mag_l} + {1'b0, mag_r};
        level = (level_sum[SAMPLE_W+1:LEVEL_W] != '0) ? '1 : level_sum[LEVEL_W-1:0];
        level_w = {level, 16'd0};

        cur_peak_env = r_in_start ? '0 : r_peak_env;
        cur_ov_env   = r_in_start ? '0 : r_ov_env;

        // attack when above, release otherwise
        if (level > cur_peak_env) begin
            peak_diff  = level - cur_peak_env;
            n_peak_env = cur_peak_env + (peak_diff >> PEAK_ATTACK_SH);
        end else begin
            peak_diff  = cur_peak_env - level;
            n_peak_env = cur_peak_env - (peak_diff >> PEAK_RELEASE_SH);
        end

        if (level_w > cur_ov_env) begin
            ov_diff  = level_w - cur_ov_env;
            n_ov_env = cur_ov_env + (ov_diff >> OV_ATTACK_SH);
        end else begin
            ov_diff  = cur_ov_env - level_w;
            n_ov_env = cur_ov_env - (ov_diff >> OV_RELEASE_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak_env  <= '0;
            r_ov_env    <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_peak_env  <= n_peak_env;
                r_ov_env    <= n_ov_env;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_left  <= i_left_sample;
            r_in_right <= i_right_sample;
            r_in_start <= i_track_start;
        end
        if (advance) begin
            r_peak_level <= n_peak_env[LEVEL_W-1 -: METER_W];
            r_ov_level   <= n_ov_env[OV_ENV_W-1 -: METER_W];
            r_info       <= slot_info;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_peak_level         = r_peak_level;
    assign o_overview_level     = r_ov_level;
    assign o_peak_slot          = r_info.peak_slot;
    assign o_peak_slot_done     = r_info.peak_done;
    assign o_overview_slot      = r_info.ov_slot;
    assign o_overview_slot_done = r_info.ov_done;

`ifndef ASSERT_OFF
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid)
        else $error("result dropped while stalled");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |-> !o_ready)
        else $error("input taken while both stages full");

    a_start_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_start |=> r_ov_level <= 8'd1)
        else $error("overview level too high after track start");
`endif

endmodule

// ===== tb/sv/apom_meter_checker.sv =====
`timescale 1ns / 1ps

module apom_meter_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [apom_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [apom_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                 i_track_start,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [apom_pkg::METER_W-1:0]         i_peak_level,
    input  logic [apom_pkg::METER_W-1:0]         i_overview_level,
    input  logic [apom_pkg::PEAK_SLOT_W-1:0]     i_peak_slot,
    input  logic                                 i_peak_slot_done,
    input  logic [apom_pkg::OV_SLOT_W-1:0]       i_overview_slot,
    input  logic                                 i_overview_slot_done,
    output int                                   o_fail_count,
    output int                                   o_outstanding
);
    import apom_pkg::*;

    typedef struct packed {
        logic [METER_W-1:0]     peak_level;
        logic [METER_W-1:0]     overview_level;
        logic [PEAK_SLOT_W-1:0] peak_slot;
        logic                   peak_done;
        logic [OV_SLOT_W-1:0]   ov_slot;
        logic                   ov_done;
    } meter_result_t;

    meter_result_t             meter_q[$];
    logic [LEVEL_W-1:0]        peak_env;
    logic [OV_ENV_W-1:0]       ov_env;
    logic [POSITION_BITS-1:0]  sample_pos;

    function automatic logic [SAMPLE_W:0] sample_magnitude(logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W:0] ext;
        ext = {s[SAMPLE_W-1], s};
        return s[SAMPLE_W-1] ? -ext : ext;
    endfunction

    // advances the envelopes and the position counter by one sample pair
    function automatic meter_result_t meter_step(logic signed [SAMPLE_W-1:0] left_s,
                                                 logic signed [SAMPLE_W-1:0] right_s,
                                                 logic start);
        logic [SAMPLE_W:0]   sum;
        logic [LEVEL_W-1:0]  lvl;
        logic [OV_ENV_W-1:0] lvl_fixed;
        logic                at_max;
        meter_result_t       res;
        if (start) begin
            peak_env   = '0;
            ov_env     = '0;
            sample_pos = '0;
        end
        sum = sample_magnitude(left_s) + sample_magnitude(right_s);
        lvl = sum[SAMPLE_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
        if (lvl > peak_env) begin
            peak_env = peak_env + ((lvl - peak_env) >> PEAK_ATTACK_SH);
        end else begin
            peak_env = peak_env - ((peak_env - lvl) >> PEAK_RELEASE_SH);
        end
        lvl_fixed = {lvl, 16'h0000};
        if (lvl_fixed > ov_env) begin
            ov_env = ov_env + ((lvl_fixed - ov_env) >> OV_ATTACK_SH);
        end else begin
            ov_env = ov_env - ((ov_env - lvl_fixed) >> OV_RELEASE_SH);
        end
        at_max             = &sample_pos;
        res.peak_level     = peak_env[LEVEL_W-1 -: METER_W];
        res.overview_level = ov_env[OV_ENV_W-1 -: METER_W];
        res.peak_slot      = PEAK_SLOT_W'(sample_pos / PEAK_DECIMATION);
        res.peak_done      = at_max || (sample_pos % PEAK_DECIMATION == PEAK_DECIMATION - 1);
        res.ov_slot        = OV_SLOT_W'(sample_pos / OVERVIEW_DECIMATION);
        res.ov_done        = at_max ||
                             (sample_pos % OVERVIEW_DECIMATION == OVERVIEW_DECIMATION - 1);
        sample_pos         = sample_pos + 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        meter_result_t want;
        if (!i_rst_n) begin
            peak_env   = '0;
            ov_env     = '0;
            sample_pos = '0;
            meter_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (meter_q.size() == 0) begin
                    report_mismatch("result transfer with no sample outstanding");
                end else begin
                    want = meter_q.pop_front();
                    check_field("peak_level", i_peak_level, want.peak_level);
                    check_field("overview_level", i_overview_level, want.overview_level);
                    check_field("peak_slot", i_peak_slot, want.peak_slot);
                    check_field("peak_slot_done", i_peak_slot_done, want.peak_done);
                    check_field("overview_slot", i_overview_slot, want.ov_slot);
                    check_field("overview_slot_done", i_overview_slot_done, want.ov_done);
                end
            end
            if (i_in_valid && i_in_ready) begin
                meter_q.push_back(meter_step(i_left_sample, i_right_sample, i_track_start));
            end
        end
        o_outstanding = meter_q.size();
    end

endmodule

// ===== tb/sv/tb_audio_peak_and_overview_meter_top.sv =====
`timescale 1ns / 1ps

module tb_audio_peak_and_overview_meter_top;
    import apom_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 11;

    typedef enum int {SEG_NOISE, SEG_LOUD, SEG_QUIET, SEG_SILENT, SEG_RAIL} segment_kind_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_left_sample;
    logic signed [SAMPLE_W-1:0] i_right_sample;
    logic                       i_track_start;
    logic                       o_valid;
    logic                       i_ready;
    logic [METER_W-1:0]         o_peak_level;
    logic [METER_W-1:0]         o_overview_level;
    logic [PEAK_SLOT_W-1:0]     o_peak_slot;
    logic                       o_peak_slot_done;
    logic [OV_SLOT_W-1:0]       o_overview_slot;
    logic                       o_overview_slot_done;

    int   fail_count;
    int   outstanding;
    int   stall_cycles;
    logic steady;

    audio_peak_and_overview_meter_top uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_left_sample        (i_left_sample),
        .i_right_sample       (i_right_sample),
        .i_track_start        (i_track_start),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_peak_level         (o_peak_level),
        .o_overview_level     (o_overview_level),
        .o_peak_slot          (o_peak_slot),
        .o_peak_slot_done     (o_peak_slot_done),
        .o_overview_slot      (o_overview_slot),
        .o_overview_slot_done (o_overview_slot_done)
    );

    apom_meter_checker meter_chk (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_valid),
        .i_in_ready           (o_ready),
        .i_left_sample        (i_left_sample),
        .i_right_sample       (i_right_sample),
        .i_track_start        (i_track_start),
        .i_out_valid          (o_valid),
        .i_out_ready          (i_ready),
        .i_peak_level         (o_peak_level),
        .i_overview_level     (o_overview_level),
        .i_peak_slot          (o_peak_slot),
        .i_peak_slot_done     (o_peak_slot_done),
        .i_overview_slot      (o_overview_slot),
        .i_overview_slot_done (o_overview_slot_done),
        .o_fail_count         (fail_count),
        .o_outstanding        (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // magnitude between lo and hi with a random sign, clipped to the sample range
    function automatic logic signed [SAMPLE_W-1:0] draw_sample(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        if ($urandom_range(1, 0)) begin
            v = -v;
        end
        if (v > 32767) begin
            v = 32767;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] left_s,
                               input logic signed [SAMPLE_W-1:0] right_s,
                               input logic start);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_left_sample  <= left_s;
        i_right_sample <= right_s;
        i_track_start  <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    initial begin
        int            remaining;
        int            seg_len;
        int            lo;
        int            hi;
        logic          seg_start;
        segment_kind_t kind;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_left_sample  <= '0;
        i_right_sample <= '0;
        i_track_start  <= 1'b0;
        steady         <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // level equal to an empty envelope, then both rails and mixed signs
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd1, -16'sd1, 1'b0);
        send_sample(16'sh5555, 16'shAAAA, 1'b0);
        send_sample(16'shAAAA, 16'sh5555, 1'b0);
        // peak envelope lands on 1000, next level matches it
        send_sample(16'sd8000, 16'sd0, 1'b1);
        send_sample(16'sd1000, 16'sd0, 1'b0);
        // overview envelope lands on 1.0, next level matches it
        send_sample(16'sd256, 16'sd0, 1'b1);
        send_sample(-16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(-16'sd32767, 16'sd0, 1'b0);
        send_sample(16'sd12345, -16'sd23456, 1'b0);

        // bursts of noise, loud, quiet, rail and silent segments so both envelopes attack and release
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            steady    <= (remaining <= 260) && (remaining > 150);
            kind      = segment_kind_t'($urandom_range(SEG_RAIL, SEG_NOISE));
            seg_len   = $urandom_range(48, 4);
            seg_start = ($urandom_range(9, 0) == 0);
            if (seg_len > remaining) begin
                seg_len = remaining;
            end
            case (kind)
                SEG_LOUD: begin
                    lo = 20000;
                    hi = 32768;
                end
                SEG_QUIET: begin
                    lo = 0;
                    hi = 300;
                end
                SEG_SILENT: begin
                    lo = 0;
                    hi = 0;
                end
                SEG_RAIL: begin
                    lo = 32767;
                    hi = 32768;
                end
                default: begin
                    lo = 0;
                    hi = 32768;
                end
            endcase
            for (int k = 0; k < seg_len; k++) begin
                send_sample(draw_sample(lo, hi), draw_sample(lo, hi),
                            (seg_start && k == 0) ||
                            (kind == SEG_NOISE && $urandom_range(49, 0) == 0));
            end
            remaining -= seg_len;
        end

        i_valid <= 1'b0;
        steady  <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
